[src/ipv4_receive_filter_assert.svh]
// Assertion macros for the IPv4 receive filter checker.
`ifndef IPV4_RECEIVE_FILTER_ASSERT_SVH
`define IPV4_RECEIVE_FILTER_ASSERT_SVH

// Clocked check, masked while reset is high.
`define IPV4RF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define IPV4RF_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/ipv4rf_pkg.sv]
// Types and constants shared by the IPv4 receive filter.
`timescale 1ns / 1ps
package ipv4rf_pkg;

  localparam logic [3:0] ST_ICMP      = 4'd0;
  localparam logic [3:0] ST_TCP       = 4'd1;
  localparam logic [3:0] ST_UDP       = 4'd2;
  localparam logic [3:0] ST_OTHER     = 4'd3;
  localparam logic [3:0] ST_SHORT     = 4'd4;
  localparam logic [3:0] ST_BAD_IHL   = 4'd5;
  localparam logic [3:0] ST_TRUNCATED = 4'd6;
  localparam logic [3:0] ST_TOTAL_LOW = 4'd7;
  localparam logic [3:0] ST_NOT_OURS  = 4'd8;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [15:0] MIN_HEADER = 16'd20;
  localparam logic [15:0] LEN_LIMIT  = 16'hFFFF;
  localparam logic [31:0] BROADCAST  = 32'hFFFF_FFFF;

  // Header byte offsets
  localparam logic [15:0] POS_VER_IHL  = 16'd0;
  localparam logic [15:0] POS_TOTAL_HI = 16'd2;
  localparam logic [15:0] POS_TOTAL_LO = 16'd3;
  localparam logic [15:0] POS_PROTO    = 16'd9;
  localparam logic [15:0] POS_SRC0     = 16'd12;
  localparam logic [15:0] POS_SRC1     = 16'd13;
  localparam logic [15:0] POS_SRC2     = 16'd14;
  localparam logic [15:0] POS_SRC3     = 16'd15;
  localparam logic [15:0] POS_DST0     = 16'd16;
  localparam logic [15:0] POS_DST1     = 16'd17;
  localparam logic [15:0] POS_DST2     = 16'd18;
  localparam logic [15:0] POS_DST3     = 16'd19;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [5:0]  payload_offset;
    logic [15:0] payload_length;
  } verdict_t;

endpackage

[src/ipv4rf_byte_if.sv]
// Byte input channel of the IPv4 receive filter.
`timescale 1ns / 1ps
interface ipv4rf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[src/ipv4rf_verdict_if.sv]
// Verdict output channel of the IPv4 receive filter.
`timescale 1ns / 1ps
interface ipv4rf_verdict_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [5:0]  payload_offset;
  logic [15:0] payload_length;

  modport source (
    output valid, output status, output protocol_number, output source_address,
    output payload_offset, output payload_length, input ready
  );
  modport sink (
    input valid, input status, input protocol_number, input source_address,
    input payload_offset, input payload_length, output ready
  );
endinterface

[src/ipv4rf_in_stage.sv]
// Input register for the byte channel.
`timescale 1ns / 1ps
module ipv4rf_in_stage import ipv4rf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ipv4rf_byte_if.sink  rx,
  input  logic         advance,
  output logic         held_valid,
  output byte_item_t   held_item
);

  assign rx.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (rx.ready) begin
      held_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      held_item <= '{data_byte: rx.data_byte, last_byte: rx.last_byte};
    end
  end

endmodule

[src/ipv4rf_parse.sv]
// Header capture and verdict logic.
`timescale 1ns / 1ps
module ipv4rf_parse import ipv4rf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] our_address,
  input  byte_item_t  item,
  input  logic        advance,
  output verdict_t    verdict
);

  logic [15:0] byte_position;
  logic [5:0]  header_bytes;
  logic [15:0] declared_total;
  logic [7:0]  protocol_seen;
  logic [31:0] source_seen;
  logic [31:0] destination_seen;

  logic [5:0]  header_bytes_next;
  logic [15:0] declared_total_next;
  logic [7:0]  protocol_seen_next;
  logic [31:0] source_seen_next;
  logic [31:0] destination_seen_next;
  logic [15:0] len;
  logic [15:0] hdr_len16;
  logic [7:0]  b;
  logic        dest_ok;

  assign b = item.data_byte;
  assign len = (byte_position == LEN_LIMIT) ? LEN_LIMIT : byte_position + 16'd1;

  always_comb begin
    header_bytes_next     = header_bytes;
    declared_total_next   = declared_total;
    protocol_seen_next    = protocol_seen;
    source_seen_next      = source_seen;
    destination_seen_next = destination_seen;
    case (byte_position)
      POS_VER_IHL:  header_bytes_next = {b[3:0], 2'b00};
      POS_TOTAL_HI: declared_total_next = {b, declared_total[7:0]};
      POS_TOTAL_LO: declared_total_next = {declared_total[15:8], b};
      POS_PROTO:    protocol_seen_next = b;
      POS_SRC0:     source_seen_next = {b, source_seen[23:0]};
      POS_SRC1:     source_seen_next = {source_seen[31:24], b, source_seen[15:0]};
      POS_SRC2:     source_seen_next = {source_seen[31:16], b, source_seen[7:0]};
      POS_SRC3:     source_seen_next = {source_seen[31:8], b};
      POS_DST0:     destination_seen_next = {b, destination_seen[23:0]};
      POS_DST1:     destination_seen_next = {destination_seen[31:24], b,
                                             destination_seen[15:0]};
      POS_DST2:     destination_seen_next = {destination_seen[31:16], b,
                                             destination_seen[7:0]};
      POS_DST3:     destination_seen_next = {destination_seen[31:8], b};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (advance) begin
      byte_position <= item.last_byte ? 16'd0 : len;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      header_bytes     <= header_bytes_next;
      declared_total   <= declared_total_next;
      protocol_seen    <= protocol_seen_next;
      source_seen      <= source_seen_next;
      destination_seen <= destination_seen_next;
    end
  end

  assign hdr_len16 = {10'd0, header_bytes_next};
  assign dest_ok = (destination_seen_next == our_address) ||
                   (destination_seen_next == BROADCAST) || (our_address == 32'd0);

  always_comb begin
    verdict.status          = ST_OTHER;
    verdict.protocol_number = protocol_seen_next;
    verdict.source_address  = source_seen_next;
    verdict.payload_offset  = header_bytes_next;
    verdict.payload_length  = 16'd0;
    if (len < MIN_HEADER) begin
      verdict.status          = ST_SHORT;
      verdict.protocol_number = 8'd0;
      verdict.source_address  = 32'd0;
      verdict.payload_offset  = 6'd0;
    end else if (hdr_len16 < MIN_HEADER || len < hdr_len16) begin
      verdict.status = ST_BAD_IHL;
    end else if (declared_total_next > len) begin
      verdict.status = ST_TRUNCATED;
    end else if (declared_total_next < hdr_len16) begin
      verdict.status = ST_TOTAL_LOW;
    end else if (!dest_ok) begin
      verdict.status = ST_NOT_OURS;
    end else begin
      verdict.payload_length = declared_total_next - hdr_len16;
      case (protocol_seen_next)
        PROTO_ICMP: verdict.status = ST_ICMP;
        PROTO_TCP:  verdict.status = ST_TCP;
        PROTO_UDP:  verdict.status = ST_UDP;
        default:    verdict.status = ST_OTHER;
      endcase
    end
  end

endmodule

[src/ipv4rf_out_stage.sv]
// Result register for the verdict channel.
`timescale 1ns / 1ps
module ipv4rf_out_stage import ipv4rf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  verdict_t            verdict_in,
  output logic                load_ok,
  ipv4rf_verdict_if.source    verdict
);

  verdict_t held;

  assign load_ok = !verdict.valid || verdict.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict.valid <= 1'b0;
    end else if (load_ok) begin
      verdict.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_ok) begin
      held <= verdict_in;
    end
  end

  assign verdict.status          = held.status;
  assign verdict.protocol_number = held.protocol_number;
  assign verdict.source_address  = held.source_address;
  assign verdict.payload_offset  = held.payload_offset;
  assign verdict.payload_length  = held.payload_length;

endmodule

[src/ipv4_receive_filter.sv]
// Top level of the IPv4 receive filter.
// Bytes of an IPv4 packet enter on rx (valid/ready), header first, with
// last_byte set on the final byte of the frame. Every frame yields exactly one
// item on verdict: status (protocol class or drop reason), protocol number,
// source address, payload offset and payload length.
// cfg_write_en/cfg_write_data load our_address; zero accepts any destination.
// Write it only while no frame is in flight.
// Throughput: one byte per cycle while no final byte waits on the result
// register, set by the single register stage on each side of the capture
// and verdict logic. The verdict is loaded into the result register at the
// edge that takes the last byte from the input register.
// Stall: while a verdict waits on verdict.ready, non-final bytes keep
// flowing; a final byte holds in the input register until the result slot
// frees, and rx.ready drops once that register is full.
// Reset: rst (synchronous) empties both registers, clears the frame byte
// count and sets our_address to zero.
`timescale 1ns / 1ps
module ipv4_receive_filter import ipv4rf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [31:0]       cfg_write_data,
  ipv4rf_byte_if.sink       rx,
  ipv4rf_verdict_if.source  verdict
);

  logic [31:0] our_address;
  logic        held_valid;
  byte_item_t  held_item;
  logic        load_ok;
  logic        advance;
  verdict_t    verdict_comb;

  always_ff @(posedge clk) begin
    if (rst) begin
      our_address <= '0;
    end else if (cfg_write_en) begin
      our_address <= cfg_write_data;
    end
  end

  assign advance = held_valid && (!held_item.last_byte || load_ok);

  ipv4rf_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  ipv4rf_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .our_address (our_address),
    .item        (held_item),
    .advance     (advance),
    .verdict     (verdict_comb)
  );

  ipv4rf_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (advance && held_item.last_byte),
    .verdict_in (verdict_comb),
    .load_ok    (load_ok),
    .verdict    (verdict)
  );

endmodule

[src/ipv4rf_checker.sv]
// Port-level checker for the IPv4 receive filter, with its bind.
`timescale 1ns / 1ps
`include "ipv4_receive_filter_assert.svh"
module ipv4rf_checker import ipv4rf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  status,
  input logic [31:0] source_address,
  input logic [7:0]  protocol_number,
  input logic [5:0]  payload_offset,
  input logic [15:0] payload_length
);

  `IPV4RF_ASSERT_RST(a_reset_empty, rst |=> !out_valid, "verdict valid after reset")
  `IPV4RF_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(status), "verdict dropped")
  `IPV4RF_ASSERT(a_status_range, out_valid |-> status <= ST_NOT_OURS, "status out of range")
  `IPV4RF_ASSERT(a_short_zero, out_valid && status == ST_SHORT |-> source_address == 32'd0 && protocol_number == 8'd0 && payload_offset == 6'd0, "short frame fields not zero")
  `IPV4RF_ASSERT(a_drop_len, out_valid && status > ST_OTHER |-> payload_length == 16'd0, "payload length on a drop")

endmodule

bind ipv4_receive_filter ipv4rf_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (verdict.valid),
  .out_ready       (verdict.ready),
  .status          (verdict.status),
  .source_address  (verdict.source_address),
  .protocol_number (verdict.protocol_number),
  .payload_offset  (verdict.payload_offset),
  .payload_length  (verdict.payload_length)
);

[dv/tb_ipv4_receive_filter.sv]
// Testbench for ipv4_receive_filter: directed and random frames checked against table verdicts and a predictor.
`timescale 1ns / 1ps
module tb_ipv4_receive_filter;
  import ipv4rf_pkg::*;

  typedef struct packed {
    byte_item_t item;
    logic       typed;
  } rx_byte_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [3:0]  ihl;
    logic [15:0] total;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
    logic [16:0] flen;
    logic        typed;
    verdict_t    want;
  } frame_row_t;

  localparam logic [31:0] ADDR_A = 32'hC0A8_0001;
  localparam logic [31:0] SRC_S  = 32'hAC10_0001;
  localparam logic [31:0] DST_X  = 32'h0A00_0002;
  localparam int NUM_ROWS = 21;

  localparam frame_row_t FRAME_ROWS [0:NUM_ROWS-1] = '{
    '{32'h0, 4'd5, 16'd20, PROTO_ICMP, SRC_S, DST_X, 17'd1, 1'b1,
      '{ST_SHORT, 8'd0, 32'd0, 6'd0, 16'd0}},
    '{32'h0, 4'd5, 16'd20, PROTO_ICMP, 32'hFFFF_FFFF, DST_X, 17'd19, 1'b1,
      '{ST_SHORT, 8'd0, 32'd0, 6'd0, 16'd0}},
    '{32'h0, 4'd5, 16'd20, PROTO_ICMP, 32'h0, DST_X, 17'd20, 1'b1,
      '{ST_ICMP, PROTO_ICMP, 32'h0, 6'd20, 16'd0}},
    '{32'h0, 4'd5, 16'd40, PROTO_TCP, 32'hFFFF_FFFF, DST_X, 17'd40, 1'b1,
      '{ST_TCP, PROTO_TCP, 32'hFFFF_FFFF, 6'd20, 16'd20}},
    '{32'h0, 4'd5, 16'd28, PROTO_UDP, 32'h0102_0304, DST_X, 17'd28, 1'b1,
      '{ST_UDP, PROTO_UDP, 32'h0102_0304, 6'd20, 16'd8}},
    '{32'h0, 4'd5, 16'd20, 8'hFF, SRC_S, DST_X, 17'd20, 1'b1,
      '{ST_OTHER, 8'hFF, SRC_S, 6'd20, 16'd0}},
    '{32'h0, 4'd5, 16'd24, 8'h00, SRC_S, DST_X, 17'd24, 1'b0, '0},
    '{32'h0, 4'd4, 16'd20, PROTO_TCP, SRC_S, DST_X, 17'd20, 1'b1,
      '{ST_BAD_IHL, PROTO_TCP, SRC_S, 6'd16, 16'd0}},
    '{32'h0, 4'd0, 16'd20, PROTO_UDP, SRC_S, DST_X, 17'd20, 1'b1,
      '{ST_BAD_IHL, PROTO_UDP, SRC_S, 6'd0, 16'd0}},
    '{32'h0, 4'd15, 16'd60, PROTO_TCP, SRC_S, DST_X, 17'd40, 1'b1,
      '{ST_BAD_IHL, PROTO_TCP, SRC_S, 6'd60, 16'd0}},
    '{32'h0, 4'd15, 16'd60, PROTO_ICMP, SRC_S, DST_X, 17'd60, 1'b1,
      '{ST_ICMP, PROTO_ICMP, SRC_S, 6'd60, 16'd0}},
    '{32'h0, 4'd5, 16'd41, PROTO_TCP, SRC_S, DST_X, 17'd40, 1'b1,
      '{ST_TRUNCATED, PROTO_TCP, SRC_S, 6'd20, 16'd0}},
    '{32'h0, 4'd5, 16'd19, PROTO_TCP, SRC_S, DST_X, 17'd40, 1'b1,
      '{ST_TOTAL_LOW, PROTO_TCP, SRC_S, 6'd20, 16'd0}},
    '{32'h0, 4'd6, 16'd0, PROTO_UDP, SRC_S, DST_X, 17'd40, 1'b0, '0},
    '{32'h0, 4'd5, 16'd30, PROTO_UDP, SRC_S, DST_X, 17'd50, 1'b0, '0},
    '{ADDR_A, 4'd5, 16'd20, PROTO_UDP, SRC_S, ADDR_A, 17'd20, 1'b0, '0},
    '{ADDR_A, 4'd5, 16'd20, PROTO_UDP, SRC_S, 32'hC0A8_0009, 17'd20, 1'b1,
      '{ST_NOT_OURS, PROTO_UDP, SRC_S, 6'd20, 16'd0}},
    '{ADDR_A, 4'd5, 16'd32, PROTO_TCP, SRC_S, BROADCAST, 17'd32, 1'b0, '0},
    '{ADDR_A, 4'd5, 16'd20, PROTO_ICMP, SRC_S, 32'h0, 17'd20, 1'b1,
      '{ST_NOT_OURS, PROTO_ICMP, SRC_S, 6'd20, 16'd0}},
    '{32'h0, 4'd5, 16'd20, PROTO_TCP, SRC_S, 32'h1234_5678, 17'd20, 1'b0, '0},
    // frame longer than the length counter
    '{32'h0, 4'd5, 16'hFFFF, PROTO_UDP, SRC_S, DST_X, 17'd65537, 1'b1,
      '{ST_UDP, PROTO_UDP, SRC_S, 6'd20, 16'hFFEB}}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [31:0] cfg_write_data = 32'h0;
  logic        tx_valid = 1'b0;
  logic [7:0]  tx_data = 8'h0;
  logic        tx_last = 1'b0;
  logic        vd_ready = 1'b0;

  ipv4rf_byte_if    rx_if ();
  ipv4rf_verdict_if vd_if ();

  assign rx_if.valid     = tx_valid;
  assign rx_if.data_byte = tx_data;
  assign rx_if.last_byte = tx_last;
  assign vd_if.ready     = vd_ready;

  ipv4_receive_filter DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .rx             (rx_if),
    .verdict        (vd_if)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [15:0] frame_pos = 16'd0;
  logic [5:0]  ihl_bytes = 6'd0;
  logic [15:0] hdr_total = 16'd0;
  logic [7:0]  proto_byte = 8'd0;
  logic [31:0] src_addr = 32'd0;
  logic [31:0] dst_addr = 32'd0;
  logic [31:0] own_addr = 32'd0;

  rx_byte_t byte_stream[$];
  verdict_t pending_verdicts[$];
  verdict_t typed_verdicts[$];

  int mismatches = 0;
  int tx_idle_pct = 0;
  int vd_idle_pct = 0;
  int hold_cnt = 0;
  logic tx_next;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
    mismatches++;
  endtask

  task automatic predict_byte(input byte_item_t it, input logic typed);
    verdict_t v;
    logic [15:0] len_now;
    logic [15:0] hdr16;
    case (frame_pos)
      POS_VER_IHL:  ihl_bytes = {it.data_byte[3:0], 2'b00};
      POS_TOTAL_HI: hdr_total[15:8] = it.data_byte;
      POS_TOTAL_LO: hdr_total[7:0] = it.data_byte;
      POS_PROTO:    proto_byte = it.data_byte;
      POS_SRC0:     src_addr[31:24] = it.data_byte;
      POS_SRC1:     src_addr[23:16] = it.data_byte;
      POS_SRC2:     src_addr[15:8] = it.data_byte;
      POS_SRC3:     src_addr[7:0] = it.data_byte;
      POS_DST0:     dst_addr[31:24] = it.data_byte;
      POS_DST1:     dst_addr[23:16] = it.data_byte;
      POS_DST2:     dst_addr[15:8] = it.data_byte;
      POS_DST3:     dst_addr[7:0] = it.data_byte;
      default: ;
    endcase
    len_now = (frame_pos == LEN_LIMIT) ? LEN_LIMIT : frame_pos + 16'd1;
    if (!it.last_byte) begin
      frame_pos = len_now;
    end else begin
      frame_pos = 16'd0;
      v = '0;
      hdr16 = {10'd0, ihl_bytes};
      if (len_now < MIN_HEADER) begin
        v.status = ST_SHORT;
      end else begin
        v.protocol_number = proto_byte;
        v.source_address = src_addr;
        v.payload_offset = ihl_bytes;
        if (hdr16 < MIN_HEADER || len_now < hdr16) v.status = ST_BAD_IHL;
        else if (hdr_total > len_now) v.status = ST_TRUNCATED;
        else if (hdr_total < hdr16) v.status = ST_TOTAL_LOW;
        else if (dst_addr != own_addr && dst_addr != BROADCAST && own_addr != 32'd0)
          v.status = ST_NOT_OURS;
        else begin
          v.payload_length = hdr_total - hdr16;
          case (proto_byte)
            PROTO_ICMP: v.status = ST_ICMP;
            PROTO_TCP:  v.status = ST_TCP;
            PROTO_UDP:  v.status = ST_UDP;
            default:    v.status = ST_OTHER;
          endcase
        end
      end
      if (typed) pending_verdicts.push_back(typed_verdicts.pop_front());
      else pending_verdicts.push_back(v);
    end
  endtask

  // byte sender
  always @(posedge clk) begin
    tx_next = tx_valid;
    if (tx_valid && rx_if.ready) begin
      predict_byte(byte_stream[0].item, byte_stream[0].typed);
      void'(byte_stream.pop_front());
      tx_next = 1'b0;
    end
    if (!tx_next && !rst && byte_stream.size() != 0 &&
        $urandom_range(99) >= tx_idle_pct) begin
      tx_next = 1'b1;
      tx_data <= byte_stream[0].item.data_byte;
      tx_last <= byte_stream[0].item.last_byte;
    end
    tx_valid <= tx_next;
  end

  // long receiver stall, counted down in cycles
  always @(posedge clk) begin
    if (hold_cnt > 0) hold_cnt = hold_cnt - 1;
  end

  // verdict receiver and checker
  always @(posedge clk) begin
    verdict_t got;
    verdict_t want;
    if (vd_ready && vd_if.valid) begin
      got = '{vd_if.status, vd_if.protocol_number, vd_if.source_address,
              vd_if.payload_offset, vd_if.payload_length};
      if (pending_verdicts.size() == 0) begin
        report_mismatch("verdict with none pending, status", 32'(got.status), 32'd0);
      end else begin
        want = pending_verdicts.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.protocol_number != want.protocol_number)
          report_mismatch("protocol_number", 32'(got.protocol_number),
                          32'(want.protocol_number));
        if (got.source_address != want.source_address)
          report_mismatch("source_address", got.source_address, want.source_address);
        if (got.payload_offset != want.payload_offset)
          report_mismatch("payload_offset", 32'(got.payload_offset),
                          32'(want.payload_offset));
        if (got.payload_length != want.payload_length)
          report_mismatch("payload_length", 32'(got.payload_length),
                          32'(want.payload_length));
      end
    end
    if (rst) begin
      vd_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      vd_ready <= 1'b0;
    end else begin
      vd_ready <= ($urandom_range(99) >= vd_idle_pct);
    end
  end

  task automatic queue_frame(input logic [3:0] ihl, input logic [15:0] total,
                             input logic [7:0] proto, input logic [31:0] src,
                             input logic [31:0] dst, input int flen, input logic typed,
                             input verdict_t want);
    rx_byte_t b;
    logic [7:0] rnd;
    logic [31:0] word;
    for (int k = 0; k < flen; k++) begin
      rnd = 8'($urandom);
      word = 32'd0;
      b.item.data_byte = rnd;
      case (k)
        32'(POS_VER_IHL):  b.item.data_byte = {rnd[7:4], ihl};
        32'(POS_TOTAL_HI): b.item.data_byte = total[15:8];
        32'(POS_TOTAL_LO): b.item.data_byte = total[7:0];
        32'(POS_PROTO):    b.item.data_byte = proto;
        32'(POS_SRC0), 32'(POS_SRC1), 32'(POS_SRC2), 32'(POS_SRC3): begin
          word = src >> (8 * (32'(POS_SRC3) - k));
          b.item.data_byte = word[7:0];
        end
        32'(POS_DST0), 32'(POS_DST1), 32'(POS_DST2), 32'(POS_DST3): begin
          word = dst >> (8 * (32'(POS_DST3) - k));
          b.item.data_byte = word[7:0];
        end
        default: ;
      endcase
      b.item.last_byte = (k == flen - 1);
      b.typed = typed && (k == flen - 1);
      byte_stream.push_back(b);
    end
    if (typed) typed_verdicts.push_back(want);
  endtask

  task automatic queue_random_frame(output int nbytes);
    int kind;
    int hdr;
    int flen;
    logic [3:0] ihl;
    logic [15:0] total;
    logic [7:0] proto;
    logic [31:0] dst;
    kind = $urandom_range(99);
    ihl = ($urandom_range(9) < 7) ? 4'd5 : 4'($urandom_range(15, 6));
    hdr = 4 * int'(ihl);
    total = 16'(hdr + $urandom_range(24));
    flen = int'(total) + (($urandom_range(3) == 0) ? $urandom_range(8, 1) : 0);
    case ($urandom_range(3))
      0: proto = PROTO_ICMP;
      1: proto = PROTO_TCP;
      2: proto = PROTO_UDP;
      default: proto = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0: dst = own_addr;
      1: dst = BROADCAST;
      2: dst = $urandom;
      default: dst = 32'd0;
    endcase
    if (kind >= 95) begin
      ihl = 4'($urandom);
      total = 16'($urandom);
      proto = 8'($urandom);
      dst = $urandom;
      flen = $urandom_range(40, 1);
    end else if (kind >= 90) begin
      total = 16'($urandom_range(hdr - 1));
    end else if (kind >= 85) begin
      total = 16'(flen + $urandom_range(40, 1));
    end else if (kind >= 80) begin
      ihl = 4'($urandom_range(15, 6));
      flen = $urandom_range(4 * int'(ihl) - 1, 20);
    end else if (kind >= 75) begin
      ihl = 4'($urandom_range(4));
    end else if (kind >= 70) begin
      flen = $urandom_range(19, 1);
    end
    queue_frame(ihl, total, proto, $urandom, dst, flen, 1'b0, '0);
    nbytes = flen;
  endtask

  task automatic wait_drained();
    while (byte_stream.size() != 0 || pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_address(input logic [31:0] addr);
    wait_drained();
    cfg_write_en <= 1'b1;
    cfg_write_data <= addr;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    own_addr = addr;
  endtask

  initial begin
    int seg_bytes;
    int seg_frames;
    int nb;
    logic [31:0] seg_addr;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    tx_idle_pct = 27;
    vd_idle_pct = 79;

    for (int i = 0; i < NUM_ROWS; i++) begin
      if (FRAME_ROWS[i].addr != own_addr) set_address(FRAME_ROWS[i].addr);
      queue_frame(FRAME_ROWS[i].ihl, FRAME_ROWS[i].total, FRAME_ROWS[i].proto,
                  FRAME_ROWS[i].src, FRAME_ROWS[i].dst, int'(FRAME_ROWS[i].flen),
                  FRAME_ROWS[i].typed, FRAME_ROWS[i].want);
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int seg = 0; seg < 2; seg++) begin
        if (seg == 1) seg_addr = $urandom;
        else if (ph == 0) seg_addr = 32'hFFFF_FFFF;
        else if (ph == 1) seg_addr = 32'h0;
        else seg_addr = 32'h0000_0001;
        set_address(seg_addr);
        if (ph == 1) begin
          tx_idle_pct = 79;
          vd_idle_pct = 27;
        end else if (ph == 2) begin
          tx_idle_pct = 0;
          vd_idle_pct = 0;
          if (seg == 0) hold_cnt = 250;
        end
        seg_bytes = 0;
        seg_frames = 0;
        while (seg_bytes < 75 || seg_frames < 8) begin
          queue_random_frame(nb);
          seg_bytes += nb;
          seg_frames++;
        end
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("ipv4_receive_filter test passed");
    end else begin
      $display("ipv4_receive_filter test failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("ipv4_receive_filter test failed");
    $finish;
  end

endmodule
